// File: sv/smrc_pkg.sv
// Shared types, constants and tables for the sumo robot mode controller.
// No dependencies; every other file in sv/ refers to this package.
`default_nettype none

package smrc_pkg;

	localparam int RANGE_SENSORS = 7;
	localparam int RANGE_W       = 12;
	localparam int SPEED_W       = 8;
	localparam int TICKS_W       = 16;
	localparam int NEAREST_W     = 4;
	localparam int SENSOR_IDX_W  = 3;
	localparam int STEP_W        = 7;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// nearest_sensor code when no reading is below the threshold
	localparam logic signed [NEAREST_W-1:0] NEAREST_NONE = 4'sb1111;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_THR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED   = 3'd5;

	// register values after reset
	localparam logic [RANGE_W-1:0]        RST_RANGE_THR    = 12'd1000;
	localparam logic [RANGE_W-1:0]        RST_LINE_THR     = 12'd1000;
	localparam logic [TICKS_W-1:0]        RST_ESCAPE_TICKS = 16'd200;
	localparam logic [STEP_W-1:0]         RST_SLEW_STEP    = 7'd5;
	localparam logic signed [SPEED_W-1:0] RST_SEARCH_SPEED = 8'sd15;
	localparam logic [STEP_W-1:0]         RST_TURN_SPEED   = 7'd20;

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_ESC_R  = 2'd1,
		MODE_ESC_L  = 2'd2,
		MODE_ATTACK = 2'd3
	} mode_t;

	typedef struct packed {
		logic [RANGE_W-1:0]        range_thr;
		logic [RANGE_W-1:0]        line_thr;
		logic [TICKS_W-1:0]        escape_ticks;
		logic [STEP_W-1:0]         slew_step;
		logic signed [SPEED_W-1:0] search_speed;
		logic [STEP_W-1:0]         turn_speed;
	} cfg_t;

	// Attack targets, indexed by nearest sensor + 1 (index 0: nobody seen).
	// Entries are trunc(20 * (1 -/+ (n - 3) / 1.5)).
	function automatic logic signed [SPEED_W-1:0] atk_right(input logic [SENSOR_IDX_W-1:0] idx);
		logic signed [SPEED_W-1:0] v;
		case (idx)
			3'd0:    v = 8'sd73;
			3'd1:    v = 8'sd60;
			3'd2:    v = 8'sd46;
			3'd3:    v = 8'sd33;
			3'd4:    v = 8'sd20;
			3'd5:    v = 8'sd6;
			3'd6:    v = -8'sd6;
			default: v = -8'sd20;
		endcase
		return v;
	endfunction

	function automatic logic signed [SPEED_W-1:0] atk_left(input logic [SENSOR_IDX_W-1:0] idx);
		logic signed [SPEED_W-1:0] v;
		case (idx)
			3'd0:    v = -8'sd33;
			3'd1:    v = -8'sd20;
			3'd2:    v = -8'sd6;
			3'd3:    v = 8'sd6;
			3'd4:    v = 8'sd20;
			3'd5:    v = 8'sd33;
			3'd6:    v = 8'sd46;
			default: v = 8'sd60;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: sv/smrc_nearest.sv
// Nearest range sensor finder: lowest reading below the threshold, first index on ties.
// Depends on smrc_pkg.
`default_nettype none

module smrc_nearest (
	input  wire logic [smrc_pkg::RANGE_W-1:0]          rng [smrc_pkg::RANGE_SENSORS],
	input  wire logic [smrc_pkg::RANGE_W-1:0]          range_thr,
	output logic signed [smrc_pkg::NEAREST_W-1:0]      nearest
);

	logic [smrc_pkg::RANGE_W-1:0]      best;
	logic [smrc_pkg::SENSOR_IDX_W-1:0] idx;
	logic                              found;

	// strict compare keeps the earlier sensor on a tie
	always_comb begin
		best  = range_thr;
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < smrc_pkg::RANGE_SENSORS; i++) begin
			if (rng[i] < best) begin
				best  = rng[i];
				idx   = smrc_pkg::SENSOR_IDX_W'(i);
				found = 1'b1;
			end
		end
		nearest = found ? $signed({1'b0, idx}) : smrc_pkg::NEAREST_NONE;
	end

endmodule

`default_nettype wire

// File: sv/smrc_mode_fsm.sv
// Mode machine (search / escape right / escape left / attack) with the escape
// tick counter and wheel target selection. Depends on smrc_pkg.
`default_nettype none

module smrc_mode_fsm (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  advance,
	input  wire smrc_pkg::cfg_t                        cfg,
	input  wire logic signed [smrc_pkg::NEAREST_W-1:0] nearest,
	input  wire logic [smrc_pkg::RANGE_W-1:0]          floor_left,
	input  wire logic [smrc_pkg::RANGE_W-1:0]          floor_right,
	output logic signed [smrc_pkg::SPEED_W-1:0]        target_right,
	output logic signed [smrc_pkg::SPEED_W-1:0]        target_left,
	output smrc_pkg::mode_t                            mode_next,
	output smrc_pkg::mode_t                            mode_now
);

	smrc_pkg::mode_t                mode_q, mode_mid;
	logic [smrc_pkg::TICKS_W-1:0]   ticks_q, ticks_inc, ticks_mid, ticks_d;
	logic                           line_l, line_r, seen;
	logic [smrc_pkg::SENSOR_IDX_W-1:0] atk_idx;
	logic signed [smrc_pkg::SPEED_W-1:0] turn_pos, turn_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= smrc_pkg::MODE_SEARCH;
			ticks_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_next;
			ticks_q <= ticks_d;
		end
	end

	always_comb begin
		ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 16'd1;
		line_l    = floor_left > cfg.line_thr;
		line_r    = floor_right > cfg.line_thr;
		seen      = (nearest != smrc_pkg::NEAREST_NONE);
		atk_idx   = nearest[smrc_pkg::SENSOR_IDX_W-1:0] + 3'd1;
		turn_pos  = $signed({1'b0, cfg.turn_speed});
		turn_neg  = -turn_pos;

		mode_mid  = mode_q;
		ticks_mid = ticks_inc;
		if ((mode_q == smrc_pkg::MODE_SEARCH || mode_q == smrc_pkg::MODE_ATTACK) &&
		    (line_l || line_r)) begin
			ticks_mid = '0;
			mode_mid  = line_l ? smrc_pkg::MODE_ESC_R : smrc_pkg::MODE_ESC_L;
		end
		// an opponent in sight overrides a line seen on the same tick
		if (seen) begin
			mode_mid  = smrc_pkg::MODE_ATTACK;
			ticks_mid = '0;
		end

		mode_next = mode_mid;
		ticks_d   = ticks_mid;
		unique case (mode_mid)
			smrc_pkg::MODE_SEARCH: begin
				target_right = cfg.search_speed;
				target_left  = cfg.search_speed;
			end
			smrc_pkg::MODE_ESC_R: begin
				target_right = turn_neg;
				target_left  = turn_pos;
				if (ticks_mid > cfg.escape_ticks) begin
					mode_next = smrc_pkg::MODE_SEARCH;
					ticks_d   = '0;
				end
			end
			smrc_pkg::MODE_ESC_L: begin
				target_right = turn_pos;
				target_left  = turn_neg;
				if (ticks_mid > cfg.escape_ticks) begin
					mode_next = smrc_pkg::MODE_SEARCH;
					ticks_d   = '0;
				end
			end
			default: begin
				// attack persists with nobody seen; table entry 0 applies
				target_right = smrc_pkg::atk_right(atk_idx);
				target_left  = smrc_pkg::atk_left(atk_idx);
			end
		endcase
	end

	assign mode_now = mode_q;

	// any mode change restarts the tick count
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != $past(mode_q)) |-> (ticks_q == '0))
		else $error("mode changed without clearing tick count");

	// leaving an escape toward search only happens once the count ran past the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (mode_q == smrc_pkg::MODE_ESC_R || mode_q == smrc_pkg::MODE_ESC_L) &&
		 !seen && mode_next == smrc_pkg::MODE_SEARCH) |-> (ticks_inc > cfg.escape_ticks))
		else $error("escape ended early");

endmodule

`default_nettype wire

// File: sv/smrc_slew.sv
// Slew limiter for one wheel: holds the current command and moves it toward
// the target by at most the step on each beat. Depends on smrc_pkg.
`default_nettype none

module smrc_slew (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                advance,
	input  wire logic signed [smrc_pkg::SPEED_W-1:0] target,
	input  wire logic [smrc_pkg::STEP_W-1:0]         step,
	output logic signed [smrc_pkg::SPEED_W-1:0]      speed
);

	logic signed [smrc_pkg::SPEED_W-1:0] speed_q, speed_d;
	logic signed [smrc_pkg::SPEED_W:0]   up, down, tgt, step_s;

	always_comb begin
		step_s = $signed({2'b00, step});
		tgt    = (smrc_pkg::SPEED_W+1)'(target);
		up     = (smrc_pkg::SPEED_W+1)'(speed_q) + step_s;
		down   = (smrc_pkg::SPEED_W+1)'(speed_q) - step_s;
		if (tgt > up)
			speed_d = smrc_pkg::SPEED_W'(up);
		else if (tgt < down)
			speed_d = smrc_pkg::SPEED_W'(down);
		else
			speed_d = target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
		end else if (advance) begin
			speed_q <= speed_d;
		end
	end

	assign speed = speed_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		((smrc_pkg::SPEED_W+1)'(speed_q) - (smrc_pkg::SPEED_W+1)'($past(speed_q))
		 <= $signed({2'b00, $past(step)})) &&
		((smrc_pkg::SPEED_W+1)'(speed_q) - (smrc_pkg::SPEED_W+1)'($past(speed_q))
		 >= -$signed({2'b00, $past(step)})))
		else $error("wheel command moved more than one step");

endmodule

`default_nettype wire

// File: sv/sumo_robot_mode_controller.sv
// Sumo robot mode controller, top level: input stage, configuration registers,
// result stage. Depends on smrc_pkg, smrc_nearest, smrc_mode_fsm, smrc_slew.
//
// One beat on the input channel is one control tick: seven range readings and
// two floor readings. The tick is held in an input register while the
// nearest-sensor search, the mode machine step and the two wheel slew limiters
// run; the result then lands in the output registers. A new tick is taken
// every cycle as long as the output side keeps up; a stalled result holds the
// input register, and in_ready drops only when both stages are full. The
// configuration registers reset to their default values; the user is to write
// them only while no tick is in flight, which the block itself does not
// enforce. An index above the last register is ignored.
`default_nettype none

module sumo_robot_mode_controller (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_wr_en,
	input  wire logic [smrc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [smrc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_0,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_1,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_2,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_3,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_4,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_5,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            range_6,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            floor_left,
	input  wire logic [smrc_pkg::RANGE_W-1:0]            floor_right,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [smrc_pkg::SPEED_W-1:0]          right_wheel,
	output logic signed [smrc_pkg::SPEED_W-1:0]          left_wheel,
	output logic [1:0]                                   mode,
	output logic signed [smrc_pkg::NEAREST_W-1:0]        nearest_sensor
);

	smrc_pkg::cfg_t cfg_q;

	logic                               valid_s1;
	logic [smrc_pkg::RANGE_W-1:0]       range_s1 [smrc_pkg::RANGE_SENSORS];
	logic [smrc_pkg::RANGE_W-1:0]       floor_left_s1, floor_right_s1;
	logic                               valid_s2;
	logic signed [smrc_pkg::NEAREST_W-1:0] nearest_s2;

	logic                               advance, take;
	logic signed [smrc_pkg::NEAREST_W-1:0] nearest;
	logic signed [smrc_pkg::SPEED_W-1:0] target_right, target_left;
	smrc_pkg::mode_t                    mode_next, mode_now;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_thr    <= smrc_pkg::RST_RANGE_THR;
			cfg_q.line_thr     <= smrc_pkg::RST_LINE_THR;
			cfg_q.escape_ticks <= smrc_pkg::RST_ESCAPE_TICKS;
			cfg_q.slew_step    <= smrc_pkg::RST_SLEW_STEP;
			cfg_q.search_speed <= smrc_pkg::RST_SEARCH_SPEED;
			cfg_q.turn_speed   <= smrc_pkg::RST_TURN_SPEED;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				smrc_pkg::CFG_RANGE_THR:    cfg_q.range_thr    <= cfg_data[smrc_pkg::RANGE_W-1:0];
				smrc_pkg::CFG_LINE_THR:     cfg_q.line_thr     <= cfg_data[smrc_pkg::RANGE_W-1:0];
				smrc_pkg::CFG_ESCAPE_TICKS: cfg_q.escape_ticks <= cfg_data[smrc_pkg::TICKS_W-1:0];
				smrc_pkg::CFG_SLEW_STEP:    cfg_q.slew_step    <= cfg_data[smrc_pkg::STEP_W-1:0];
				smrc_pkg::CFG_SEARCH_SPEED:
					cfg_q.search_speed <= $signed(cfg_data[smrc_pkg::SPEED_W-1:0]);
				smrc_pkg::CFG_TURN_SPEED:   cfg_q.turn_speed   <= cfg_data[smrc_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result stage is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			range_s1[0]    <= range_0;
			range_s1[1]    <= range_1;
			range_s1[2]    <= range_2;
			range_s1[3]    <= range_3;
			range_s1[4]    <= range_4;
			range_s1[5]    <= range_5;
			range_s1[6]    <= range_6;
			floor_left_s1  <= floor_left;
			floor_right_s1 <= floor_right;
		end
		if (advance)
			nearest_s2 <= nearest;
	end

	smrc_nearest u_nearest (
		.rng       (range_s1),
		.range_thr (cfg_q.range_thr),
		.nearest   (nearest)
	);

	smrc_mode_fsm u_mode_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.cfg          (cfg_q),
		.nearest      (nearest),
		.floor_left   (floor_left_s1),
		.floor_right  (floor_right_s1),
		.target_right (target_right),
		.target_left  (target_left),
		.mode_next    (mode_next),
		.mode_now     (mode_now)
	);

	smrc_slew u_slew_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.target  (target_right),
		.step    (cfg_q.slew_step),
		.speed   (right_wheel)
	);

	smrc_slew u_slew_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.target  (target_left),
		.step    (cfg_q.slew_step),
		.speed   (left_wheel)
	);

	assign out_valid      = valid_s2;
	assign mode           = mode_now;
	assign nearest_sensor = nearest_s2;

	// a sensor in sight always means attack
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && nearest_s2 != smrc_pkg::NEAREST_NONE) |-> (mode_now == smrc_pkg::MODE_ATTACK))
		else $error("opponent reported outside attack mode");

	// an empty result stage never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with result stage empty");

	// a tick in stage 1 with the result stage empty shows up next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("tick did not reach the result stage");

	// the mode output follows the machine's next mode on each beat
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (mode_now == $past(mode_next)))
		else $error("mode register missed an update");

endmodule

`default_nettype wire
